>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they expand to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/bmed_pkg.sv
// ---------------------------------------------------------------------------
// bmed_pkg
// Types and fixed constants of the binary erosion and dilation unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmed_pkg;

   localparam int WORD_W             = 64;
   localparam int ROW_OUT_W          = 12;
   localparam int COL_OUT_W          = 6;
   localparam int KERNEL_RADIUS_LIMIT = 3;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 13;

   localparam int RSP_FIFO_DEPTH = 8;
   localparam int RSP_FIFO_PTR_W = 3;
   localparam int RSP_FIFO_CNT_W = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DILATE_MODE   = 4'd0,
      CSR_KERNEL_RADIUS = 4'd1,
      CSR_WIDTH_WORDS   = 4'd2,
      CSR_HEIGHT_ROWS   = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0] pixel_word;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0]    out_word;
      logic [ROW_OUT_W-1:0] out_row;
      logic [COL_OUT_W-1:0] out_col;
      logic                 image_end;
   } rsp_payload_type;

   // Operation and kernel size as seen by the lanes and the merge stage.
   typedef struct packed {
      logic       dilate;
      logic [1:0] radius;
   } morph_ctrl_type;

endpackage

>>> sv/bmed_chan_if.sv
// ---------------------------------------------------------------------------
// bmed_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bmed_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/binary_morph_erode_dilate_unit.sv
// ---------------------------------------------------------------------------
// binary_morph_erode_dilate_unit: a result is registered in stage 1, in the lanes and in the output queue.
// Throughput one input word per cycle while the output queue has room; a row end gives two results.
// Synchronous active-high reset clears counters, windows, pipeline and queue; no clear pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Structure
//   Stage 0: an input transfer writes the word into the line store row chosen
//            by the row number modulo the number of store rows, and reads the same
//            column from every row of the store; the read data is registered.
//   Stage 1: the kernel column is assembled from the store rows in age order
//            plus the new word. One lane per kernel row reduces that row
//            horizontally, for the word left of the current column and, at the
//            row end, for the last word of the row. The word windows of the
//            two previous columns are updated here.
//   Stage 2: the merge stage combines the active lanes vertically and pushes
//            zero, one or two results into a small output queue.
// The pipeline itself never stalls. Input is taken only while the queue has
// room for every result still in flight, so output backpressure is absorbed
// without loss. A defined CSR write restarts the image: the counters and
// windows return to zero while the line store keeps its contents.

module binary_morph_erode_dilate_unit #(
   parameter int MAX_WORDS  = 64,
   parameter int MAX_ROWS   = 4096,
   parameter int MAX_RADIUS = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   bmed_chan_if.sink                        req_chan,
   bmed_chan_if.source                      rsp_chan,
   input  logic                             csr_write_en,
   input  logic [bmed_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bmed_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bmed_pkg::*;

   localparam int SLOTS = 2 * MAX_RADIUS;
   localparam int WIN   = SLOTS + 1;
   localparam int SW    = $clog2(SLOTS);
   localparam int CW    = $clog2(MAX_WORDS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int WXW   = (CW + 1 > 7) ? CW + 1 : 7;
   localparam int HXW   = (RW + 1 > 13) ? RW + 1 : 13;
   localparam int ORW   = (RW > ROW_OUT_W) ? RW : ROW_OUT_W;
   localparam int OCW   = (CW > COL_OUT_W) ? CW : COL_OUT_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic        dilate_ff, dilate_in;
   logic [1:0]  radius_ff, radius_in;
   logic [6:0]  width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic        restart;

   always_comb begin
      dilate_in = dilate_ff;
      radius_in = radius_ff;
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DILATE_MODE: begin
               dilate_in = csr_wdata[0];
               restart   = 1'b1;
            end
            CSR_KERNEL_RADIUS: begin
               radius_in = csr_wdata[1:0];
               restart   = 1'b1;
            end
            CSR_WIDTH_WORDS: begin
               width_in = csr_wdata[6:0];
               restart  = 1'b1;
            end
            CSR_HEIGHT_ROWS: begin
               height_in = csr_wdata[12:0];
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dilate_ff <= 1'b0;
         radius_ff <= 2'd1;
         width_ff  <= 7'd2;
         height_ff <= 13'd1;
      end else begin
         dilate_ff <= dilate_in;
         radius_ff <= radius_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Out-of-range settings are saturated into the supported range.
   logic [1:0]     rad_eff;
   logic [2:0]     two_rad;
   logic [WXW-1:0] w_clamp, w_last_ext;
   logic [HXW-1:0] h_clamp, h_last_ext;
   logic [CW-1:0]  w_last;
   logic [RW-1:0]  h_last;
   morph_ctrl_type ctrl;

   always_comb begin
      if (radius_ff == 2'd0) begin
         rad_eff = 2'd1;
      end else if (radius_ff > 2'(MAX_RADIUS)) begin
         rad_eff = 2'(MAX_RADIUS);
      end else begin
         rad_eff = radius_ff;
      end
      two_rad = {rad_eff, 1'b0};

      w_clamp = WXW'(width_ff);
      if (w_clamp < WXW'(2)) begin
         w_clamp = WXW'(2);
      end else if (w_clamp > WXW'(MAX_WORDS)) begin
         w_clamp = WXW'(MAX_WORDS);
      end
      w_last_ext = w_clamp - WXW'(1);
      w_last     = w_last_ext[CW-1:0];

      h_clamp = HXW'(height_ff);
      if (h_clamp == '0) begin
         h_clamp = HXW'(1);
      end else if (h_clamp > HXW'(MAX_ROWS)) begin
         h_clamp = HXW'(MAX_ROWS);
      end
      h_last_ext = h_clamp - HXW'(1);
      h_last     = h_last_ext[RW-1:0];

      ctrl.dilate = dilate_ff;
      ctrl.radius = rad_eff;
   end

   // ---------------------------------------------------------------------
   // Stage 0: position counters, line store access
   // ---------------------------------------------------------------------
   logic          req_accept;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [SW-1:0] rowmod_ff, rowmod_in;
   logic          col_last, row_last, active;
   logic [SW:0]   base_sum;
   logic [SW-1:0] base_slot;
   logic [ORW-1:0] row_out_ext;
   logic [OCW-1:0] col_a_ext, col_b_ext;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign col_last   = (col_ff == w_last);
   assign row_last   = (row_ff == h_last);
   assign active     = (ORW'(row_ff) >= ORW'(two_rad));
   assign row_out_ext = ORW'(row_ff) - ORW'(rad_eff);
   assign col_a_ext   = OCW'(col_ff) - OCW'(1);
   assign col_b_ext   = OCW'(col_ff);

   // Store row holding the oldest kernel row of this column.
   always_comb begin
      base_sum = (SW + 1)'(rowmod_ff) + (SW + 1)'(SLOTS) - (SW + 1)'(two_rad);
      if (base_sum >= (SW + 1)'(SLOTS)) begin
         base_sum = base_sum - (SW + 1)'(SLOTS);
      end
      base_slot = base_sum[SW-1:0];
   end

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      rowmod_in = rowmod_ff;
      if (req_accept) begin
         if (col_last) begin
            col_in = '0;
            if (row_last) begin
               row_in    = '0;
               rowmod_in = '0;
            end else begin
               row_in    = row_ff + RW'(1);
               rowmod_in = (rowmod_ff == SW'(SLOTS - 1)) ? '0 : rowmod_ff + SW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff    <= '0;
         row_ff    <= '0;
         rowmod_ff <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         rowmod_ff <= rowmod_in;
      end
   end

   logic [SLOTS-1:0][WORD_W-1:0] ram_rd;

   for (genvar s = 0; s < SLOTS; s++) begin : g_line
      bmed_line_ram #(
         .DEPTH  (MAX_WORDS),
         .ADDR_W (CW)
      ) u_line_ram (
         .clock   (clock),
         .wr_en   (req_accept && (rowmod_ff == SW'(s))),
         .wr_addr (col_ff),
         .wr_data (req_chan.payload.pixel_word),
         .rd_en   (req_accept),
         .rd_addr (col_ff),
         .rd_data (ram_rd[s])
      );
   end

   // Stage 1 registers. The result flags say which of the two possible
   // results this word completes: the word to its left, and the last word.
   logic                 s1_valid_ff;
   logic [WORD_W-1:0]    s1_word_ff;
   logic                 s1_first_ff;
   logic                 s1_na_ff, s1_nb_ff;
   logic [ROW_OUT_W-1:0] s1_row_ff;
   logic [COL_OUT_W-1:0] s1_cola_ff, s1_colb_ff;
   logic                 s1_end_ff;
   logic [SW-1:0]        s1_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_word_ff  <= req_chan.payload.pixel_word;
         s1_first_ff <= (col_ff == '0);
         s1_na_ff    <= active && (col_ff != '0);
         s1_nb_ff    <= active && col_last;
         s1_row_ff   <= row_out_ext[ROW_OUT_W-1:0];
         s1_cola_ff  <= col_a_ext[COL_OUT_W-1:0];
         s1_colb_ff  <= col_b_ext[COL_OUT_W-1:0];
         s1_end_ff   <= row_last;
         s1_base_ff  <= base_slot;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: kernel column, word windows, lanes
   // ---------------------------------------------------------------------
   logic [WIN-1:0][WORD_W-1:0] col_word;
   logic [WIN-1:0][WORD_W-1:0] win_cur_ff, win_cur_in;
   logic [WIN-1:0][WORD_W-1:0] win_prev_ff, win_prev_in;

   always_comb begin
      logic [SW:0] slot_sum;
      for (int t = 0; t < WIN; t++) begin
         slot_sum = (SW + 1)'(s1_base_ff) + (SW + 1)'(t);
         if (slot_sum >= (SW + 1)'(SLOTS)) begin
            slot_sum = slot_sum - (SW + 1)'(SLOTS);
         end
         if (t < int'(two_rad)) begin
            col_word[t] = ram_rd[slot_sum[SW-1:0]];
         end else if (t == int'(two_rad)) begin
            col_word[t] = s1_word_ff;
         end else begin
            col_word[t] = '0;
         end
      end
   end

   // At the start of a row the left-hand window reads as beyond the edge.
   always_comb begin
      win_cur_in  = win_cur_ff;
      win_prev_in = win_prev_ff;
      if (s1_valid_ff) begin
         win_prev_in = s1_first_ff ? '0 : win_cur_ff;
         win_cur_in  = col_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         win_cur_ff  <= '0;
         win_prev_ff <= '0;
      end else begin
         win_cur_ff  <= win_cur_in;
         win_prev_ff <= win_prev_in;
      end
   end

   logic [WIN-1:0][WORD_W-1:0] lane_a, lane_b;

   for (genvar t = 0; t < WIN; t++) begin : g_lane
      bmed_lane u_lane (
         .clock      (clock),
         .enable     (s1_valid_ff),
         .ctrl       (ctrl),
         .left_word  (win_prev_ff[t]),
         .mid_word   (win_cur_ff[t]),
         .right_word (col_word[t]),
         .h_a        (lane_a[t]),
         .h_b        (lane_b[t])
      );
   end

   logic                 s2_valid_ff;
   logic                 s2_na_ff, s2_nb_ff;
   logic [ROW_OUT_W-1:0] s2_row_ff;
   logic [COL_OUT_W-1:0] s2_cola_ff, s2_colb_ff;
   logic                 s2_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_na_ff   <= s1_na_ff;
         s2_nb_ff   <= s1_nb_ff;
         s2_row_ff  <= s1_row_ff;
         s2_cola_ff <= s1_cola_ff;
         s2_colb_ff <= s1_colb_ff;
         s2_end_ff  <= s1_end_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: merge and output queue
   // ---------------------------------------------------------------------
   logic [WORD_W-1:0] res_a, res_b;

   bmed_merge #(
      .LANES (WIN)
   ) u_merge (
      .ctrl   (ctrl),
      .lane_a (lane_a),
      .lane_b (lane_b),
      .res_a  (res_a),
      .res_b  (res_b)
   );

   rsp_payload_type             fifo_mem_ff [RSP_FIFO_DEPTH];
   logic [RSP_FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_FIFO_CNT_W-1:0]   fifo_count_ff, fifo_count_in;
   logic                        push_a, push_b, pop;
   logic [1:0]                  n_push;
   logic [RSP_FIFO_PTR_W-1:0]   wr_ptr_b;
   rsp_payload_type             entry_a, entry_b;
   logic [2:0]                  s1_pending, s2_pending;
   logic [RSP_FIFO_CNT_W:0]     committed;

   assign push_a   = s2_valid_ff && s2_na_ff;
   assign push_b   = s2_valid_ff && s2_nb_ff;
   assign n_push   = 2'(push_a) + 2'(push_b);
   assign wr_ptr_b = wr_ptr_ff + RSP_FIFO_PTR_W'(push_a);
   assign pop      = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      entry_a.out_word  = res_a;
      entry_a.out_row   = s2_row_ff;
      entry_a.out_col   = s2_cola_ff;
      entry_a.image_end = 1'b0;
      entry_b.out_word  = res_b;
      entry_b.out_row   = s2_row_ff;
      entry_b.out_col   = s2_colb_ff;
      entry_b.image_end = s2_end_ff;
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         fifo_mem_ff[wr_ptr_ff] <= entry_a;
      end
      if (push_b) begin
         fifo_mem_ff[wr_ptr_b] <= entry_b;
      end
   end

   always_comb begin
      wr_ptr_in     = wr_ptr_ff + RSP_FIFO_PTR_W'(n_push);
      rd_ptr_in     = rd_ptr_ff + RSP_FIFO_PTR_W'(pop);
      fifo_count_in = fifo_count_ff + RSP_FIFO_CNT_W'(n_push) - RSP_FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fifo_count_ff <= fifo_count_in;
      end
   end

   // Input is taken only if the queue can hold everything still in flight
   // plus the two results a new word may complete. Nothing is taken in reset.
   assign s1_pending = s1_valid_ff ? 3'(s1_na_ff) + 3'(s1_nb_ff) : 3'd0;
   assign s2_pending = s2_valid_ff ? 3'(s2_na_ff) + 3'(s2_nb_ff) : 3'd0;
   assign committed  = (RSP_FIFO_CNT_W + 1)'(fifo_count_ff)
                     + (RSP_FIFO_CNT_W + 1)'(s1_pending)
                     + (RSP_FIFO_CNT_W + 1)'(s2_pending);

   assign req_chan.ready = !reset
                           && ((committed + (RSP_FIFO_CNT_W + 1)'(2))
                               <= (RSP_FIFO_CNT_W + 1)'(RSP_FIFO_DEPTH));

   assign rsp_chan.valid   = (fifo_count_ff != '0);
   assign rsp_chan.payload = fifo_mem_ff[rd_ptr_ff];

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // The queue always has room for what the merge stage pushes.
   `ASSERT_IMPLY(a_fifo_room, clock, reset, s2_valid_ff, ((RSP_FIFO_CNT_W + 1)'(fifo_count_ff) + (RSP_FIFO_CNT_W + 1)'(s2_pending)) <= (RSP_FIFO_CNT_W + 1)'(RSP_FIFO_DEPTH))
   // A word that ends an active row also completes its left neighbour.
   `ASSERT_IMPLY(a_row_end_pair, clock, reset, s1_valid_ff && s1_nb_ff, s1_na_ff)
   // Every input transfer enters stage 1 on the next cycle with its word.
   `ASSERT_NEXT(a_stage_follow, clock, reset, req_accept, s1_valid_ff && (s1_word_ff == $past(req_chan.payload.pixel_word)))

endmodule

>>> sv/bmed_line_ram.sv
// ---------------------------------------------------------------------------
// bmed_line_ram
// One row of the line store: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmed_line_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [bmed_pkg::WORD_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [bmed_pkg::WORD_W-1:0] rd_data
);
   import bmed_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bmed_lane.sv
// ---------------------------------------------------------------------------
// bmed_lane
// Horizontal reduction of one kernel row for both candidate result words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmed_lane (
   input  logic                        clock,
   input  logic                        enable,
   input  bmed_pkg::morph_ctrl_type    ctrl,
   input  logic [bmed_pkg::WORD_W-1:0] left_word,
   input  logic [bmed_pkg::WORD_W-1:0] mid_word,
   input  logic [bmed_pkg::WORD_W-1:0] right_word,
   output logic [bmed_pkg::WORD_W-1:0] h_a,
   output logic [bmed_pkg::WORD_W-1:0] h_b
);
   import bmed_pkg::*;

   logic [WORD_W-1:0] h_a_ff;
   logic [WORD_W-1:0] h_b_ff;
   logic [WORD_W-1:0] h_a_in;
   logic [WORD_W-1:0] h_b_in;

   // Combine the centre word with its neighbours shifted in from either side,
   // one shift distance per kernel step.
   function automatic logic [WORD_W-1:0] hline(
      input logic [WORD_W-1:0] l,
      input logic [WORD_W-1:0] m,
      input logic [WORD_W-1:0] r,
      input logic [1:0]        radius,
      input logic              dilate
   );
      logic [WORD_W-1:0] acc;
      logic [WORD_W-1:0] from_r;
      logic [WORD_W-1:0] from_l;
      acc = m;
      for (int s = 1; s <= KERNEL_RADIUS_LIMIT; s++) begin
         from_r = (m << s) | (r >> (WORD_W - s));
         from_l = (m >> s) | (l << (WORD_W - s));
         if (s <= int'(radius)) begin
            acc = dilate ? (acc | from_r | from_l) : (acc & from_r & from_l);
         end
      end
      return acc;
   endfunction

   // The word to the left of the current column, and the word at the row end
   // whose right neighbour lies beyond the edge.
   always_comb begin
      h_a_in = hline(left_word, mid_word, right_word, ctrl.radius, ctrl.dilate);
      h_b_in = hline(mid_word, right_word, '0, ctrl.radius, ctrl.dilate);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         h_a_ff <= h_a_in;
         h_b_ff <= h_b_in;
      end
   end

   assign h_a = h_a_ff;
   assign h_b = h_b_ff;

endmodule

>>> sv/bmed_merge.sv
// ---------------------------------------------------------------------------
// bmed_merge
// Vertical combination of the lane results over the active kernel rows.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmed_merge #(
   parameter int LANES = 7
) (
   input  bmed_pkg::morph_ctrl_type               ctrl,
   input  logic [LANES-1:0][bmed_pkg::WORD_W-1:0] lane_a,
   input  logic [LANES-1:0][bmed_pkg::WORD_W-1:0] lane_b,
   output logic [bmed_pkg::WORD_W-1:0]            res_a,
   output logic [bmed_pkg::WORD_W-1:0]            res_b
);
   import bmed_pkg::*;

   // Lanes above twice the radius carry rows outside the kernel and are skipped.
   always_comb begin
      res_a = ctrl.dilate ? '0 : '1;
      res_b = ctrl.dilate ? '0 : '1;
      for (int t = 0; t < LANES; t++) begin
         if (t <= int'({ctrl.radius, 1'b0})) begin
            res_a = ctrl.dilate ? (res_a | lane_a[t]) : (res_a & lane_a[t]);
            res_b = ctrl.dilate ? (res_b | lane_b[t]) : (res_b & lane_b[t]);
         end
      end
   end

endmodule
